### sv/hrbp_pkg.sv
package hrbp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int VERSION_BITS_DEF = 16;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [2:0] TG_DELIM  = 3'd0;
    localparam logic [2:0] TG_METHOD = 3'd1;
    localparam logic [2:0] TG_URI    = 3'd2;
    localparam logic [2:0] TG_VER    = 3'd3;
    localparam logic [2:0] TG_NAME   = 3'd4;
    localparam logic [2:0] TG_VALUE  = 3'd5;
    localparam logic [2:0] TG_BODY   = 3'd6;

    localparam logic [4:0] P_METHOD0 = 5'd0;
    localparam logic [4:0] P_METHOD  = 5'd1;
    localparam logic [4:0] P_URI     = 5'd2;
    localparam logic [4:0] P_H       = 5'd3;
    localparam logic [4:0] P_T1      = 5'd4;
    localparam logic [4:0] P_T2      = 5'd5;
    localparam logic [4:0] P_P       = 5'd6;
    localparam logic [4:0] P_SLASH   = 5'd7;
    localparam logic [4:0] P_MAJ0    = 5'd8;
    localparam logic [4:0] P_MAJ     = 5'd9;
    localparam logic [4:0] P_MIN0    = 5'd10;
    localparam logic [4:0] P_MIN     = 5'd11;
    localparam logic [4:0] P_REQLF   = 5'd12;
    localparam logic [4:0] P_LINE    = 5'd13;
    localparam logic [4:0] P_NAME    = 5'd14;
    localparam logic [4:0] P_COLSP   = 5'd15;
    localparam logic [4:0] P_VALUE   = 5'd16;
    localparam logic [4:0] P_LINELF  = 5'd17;
    localparam logic [4:0] P_CONTWS  = 5'd18;
    localparam logic [4:0] P_FINLF   = 5'd19;
    localparam logic [4:0] P_BODY    = 5'd20;

    localparam logic [3:0] CL_NAME_LEN = 4'd14;

    function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= 8'd31) || (c == 8'd127);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic s;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", " ", 8'd9: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return (c < 8'd127) && !is_ctl(c) && !is_sep(c);
    endfunction

endpackage

### sv/hrbp_in_if.sv
interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

### sv/hrbp_out_if.sv
interface hrbp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [2:0]  field_tag;
    logic [7:0]  out_byte;
    logic        header_start;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [31:0] body_length;

    modport source (output valid, output parse_status, output field_tag, output out_byte,
                    output header_start, output version_major, output version_minor,
                    output body_length, input ready);
    modport sink (input valid, input parse_status, input field_tag, input out_byte,
                  input header_start, input version_major, input version_minor,
                  input body_length, output ready);
endinterface

### sv/http_request_byte_parser_unit.sv
// HTTP/1.1 request byte parser.
// The in channel carries one raw request byte per transfer. The out channel
// returns exactly one result per input byte: status, field tag, the byte
// itself, a header-start flag, the version numbers seen so far and, after
// the header block, the latched Content-Length.
// The result of a byte is registered at the edge that accepts it.
// Throughput is one byte per cycle while results are taken, set by the
// single grammar step between the input handshake and the result register.
// The result register is the only stage; a new byte is taken whenever the
// result register is empty or its result is taken in the same cycle. When
// the receiver stalls, the result holds and input ready drops.
// Reset clears all parser state to the start of a method and empties the
// result register. After a result with status complete or error, the parser
// starts over at the next byte.
// Content-Length values wider than LENGTH_BITS and version numbers above
// 2^VERSION_BITS - 1 are an error and saturate respectively.
module http_request_byte_parser_unit #(
    parameter int LENGTH_BITS  = hrbp_pkg::LENGTH_BITS_DEF,
    parameter int VERSION_BITS = hrbp_pkg::VERSION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    hrbp_in_if.sink    in_ch,
    hrbp_out_if.source out_ch
);

    localparam logic [VERSION_BITS-1:0] VMAX = {VERSION_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0]  LMAX = {LENGTH_BITS{1'b1}};
    localparam logic [VERSION_BITS-1:0] VLIM = VMAX / 10;
    localparam logic [LENGTH_BITS-1:0]  LLIM = LMAX / 10;
    localparam logic [3:0] VREM = 4'(VMAX % 10);
    localparam logic [3:0] LREM = 4'(LMAX % 10);

    logic [4:0]              pos_reg, pos_next;
    logic [VERSION_BITS-1:0] major_reg, major_next, minor_reg, minor_next;
    logic                    seen_reg, seen_next;
    logic [3:0]              nmpos_reg, nmpos_next;
    logic                    nmis_reg, nmis_next;
    logic                    inlen_reg, inlen_next;
    logic [LENGTH_BITS-1:0]  vacc_reg, vacc_next;
    logic                    vdig_reg, vdig_next;
    logic                    lbad_reg, lbad_next;
    logic [LENGTH_BITS-1:0]  llat_reg, llat_next;
    logic [LENGTH_BITS-1:0]  bcnt_reg, bcnt_next;

    logic        ovalid_reg;
    logic [1:0]  st_reg;
    logic [2:0]  tag_reg;
    logic [7:0]  byte_reg;
    logic        hs_reg;
    logic [15:0] vmaj_reg, vmin_reg;
    logic [31:0] blen_reg;

    logic [1:0] st;
    logic [2:0] tag;
    logic       hs, show_len, take;
    logic [7:0] c, lc;
    logic [3:0] d;
    logic [LENGTH_BITS-1:0] llat_out;

    assign c = in_ch.in_byte;
    assign d = c[3:0];
    assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign in_ch.ready = !ovalid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;

    always_comb
    begin
        pos_next = pos_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        seen_next = seen_reg;
        nmpos_next = nmpos_reg;
        nmis_next = nmis_reg;
        inlen_next = inlen_reg;
        vacc_next = vacc_reg;
        vdig_next = vdig_reg;
        lbad_next = lbad_reg;
        llat_next = llat_reg;
        bcnt_next = bcnt_reg;
        st = hrbp_pkg::ST_MORE;
        tag = hrbp_pkg::TG_DELIM;
        hs = 1'b0;
        show_len = 1'b0;
        llat_out = llat_reg;
        case (pos_reg)
            hrbp_pkg::P_METHOD0, hrbp_pkg::P_METHOD:
            begin
                if (hrbp_pkg::is_token(c))
                begin
                    tag = hrbp_pkg::TG_METHOD;
                    pos_next = hrbp_pkg::P_METHOD;
                end
                else if (c == " " && pos_reg == hrbp_pkg::P_METHOD)
                    pos_next = hrbp_pkg::P_URI;
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_URI:
            begin
                if (c == " ")
                    pos_next = hrbp_pkg::P_H;
                else if (!hrbp_pkg::is_ctl(c))
                    tag = hrbp_pkg::TG_URI;
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_H:
                if (c == "H") pos_next = hrbp_pkg::P_T1; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_T1:
                if (c == "T") pos_next = hrbp_pkg::P_T2; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_T2:
                if (c == "T") pos_next = hrbp_pkg::P_P; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_P:
                if (c == "P") pos_next = hrbp_pkg::P_SLASH; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_SLASH:
                if (c == "/") pos_next = hrbp_pkg::P_MAJ0; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_MAJ0, hrbp_pkg::P_MAJ:
            begin
                if (hrbp_pkg::is_digit(c))
                begin
                    tag = hrbp_pkg::TG_VER;
                    pos_next = hrbp_pkg::P_MAJ;
                    if (major_reg > VLIM || (major_reg == VLIM && d > VREM))
                        major_next = VMAX;
                    else
                        major_next = VERSION_BITS'(major_reg * 10)
                                     + VERSION_BITS'(d);
                end
                else if (c == "." && pos_reg == hrbp_pkg::P_MAJ)
                    pos_next = hrbp_pkg::P_MIN0;
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_MIN0, hrbp_pkg::P_MIN:
            begin
                if (hrbp_pkg::is_digit(c))
                begin
                    tag = hrbp_pkg::TG_VER;
                    pos_next = hrbp_pkg::P_MIN;
                    if (minor_reg > VLIM || (minor_reg == VLIM && d > VREM))
                        minor_next = VMAX;
                    else
                        minor_next = VERSION_BITS'(minor_reg * 10)
                                     + VERSION_BITS'(d);
                end
                else if (c == 8'd13 && pos_reg == hrbp_pkg::P_MIN)
                    pos_next = hrbp_pkg::P_REQLF;
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_REQLF, hrbp_pkg::P_LINELF:
                if (c == 8'd10) pos_next = hrbp_pkg::P_LINE; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_LINE:
            begin
                if (c == " " || c == 8'd9)
                begin
                    if (seen_reg) pos_next = hrbp_pkg::P_CONTWS;
                    else st = hrbp_pkg::ST_ERR;
                end
                else if (hrbp_pkg::is_token(c) || c == 8'd13)
                begin
                    if (inlen_reg)
                    begin
                        if (!vdig_reg) lbad_next = 1'b1;
                        else llat_next = vacc_reg;
                    end
                    inlen_next = 1'b0;
                    vacc_next = '0;
                    vdig_next = 1'b0;
                    if (c == 8'd13)
                        pos_next = hrbp_pkg::P_FINLF;
                    else
                    begin
                        seen_next = 1'b1;
                        if (lc == hrbp_pkg::cl_name_char(4'd0))
                        begin
                            nmpos_next = 4'd1;
                            nmis_next = 1'b0;
                        end
                        else
                        begin
                            nmpos_next = 4'd0;
                            nmis_next = 1'b1;
                        end
                        tag = hrbp_pkg::TG_NAME;
                        hs = 1'b1;
                        pos_next = hrbp_pkg::P_NAME;
                    end
                end
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_NAME:
            begin
                if (hrbp_pkg::is_token(c))
                begin
                    tag = hrbp_pkg::TG_NAME;
                    if (!nmis_reg && nmpos_reg < hrbp_pkg::CL_NAME_LEN
                        && lc == hrbp_pkg::cl_name_char(nmpos_reg))
                        nmpos_next = nmpos_reg + 4'd1;
                    else
                        nmis_next = 1'b1;
                end
                else if (c == ":")
                begin
                    inlen_next = !nmis_reg && nmpos_reg == hrbp_pkg::CL_NAME_LEN;
                    pos_next = hrbp_pkg::P_COLSP;
                end
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_COLSP:
                if (c == " ") pos_next = hrbp_pkg::P_VALUE; else st = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_CONTWS, hrbp_pkg::P_VALUE:
            begin
                if (pos_reg == hrbp_pkg::P_CONTWS && (c == " " || c == 8'd9))
                    pos_next = pos_reg;
                else if (c == 8'd13)
                    pos_next = hrbp_pkg::P_LINELF;
                else if (c < 8'd127 && !hrbp_pkg::is_ctl(c))
                begin
                    tag = hrbp_pkg::TG_VALUE;
                    pos_next = hrbp_pkg::P_VALUE;
                    if (inlen_reg)
                    begin
                        if (!hrbp_pkg::is_digit(c))
                            lbad_next = 1'b1;
                        else if (vacc_reg > LLIM || (vacc_reg == LLIM && d > LREM))
                            lbad_next = 1'b1;
                        else
                        begin
                            vacc_next = LENGTH_BITS'(vacc_reg * 10) + LENGTH_BITS'(d);
                            vdig_next = 1'b1;
                        end
                    end
                end
                else
                    st = hrbp_pkg::ST_ERR;
            end
            hrbp_pkg::P_FINLF:
            begin
                if (c != 8'd10 || lbad_reg)
                    st = hrbp_pkg::ST_ERR;
                else
                begin
                    show_len = 1'b1;
                    bcnt_next = '0;
                    if (llat_reg == '0) st = hrbp_pkg::ST_DONE;
                    else pos_next = hrbp_pkg::P_BODY;
                end
            end
            hrbp_pkg::P_BODY:
            begin
                tag = hrbp_pkg::TG_BODY;
                show_len = 1'b1;
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg + 1'b1 >= llat_reg) st = hrbp_pkg::ST_DONE;
            end
            default:
                st = hrbp_pkg::ST_ERR;
        endcase
        if (st == hrbp_pkg::ST_ERR)
            tag = hrbp_pkg::TG_DELIM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= hrbp_pkg::P_METHOD0;
            major_reg <= '0;
            minor_reg <= '0;
            seen_reg <= 1'b0;
            nmpos_reg <= '0;
            nmis_reg <= 1'b0;
            inlen_reg <= 1'b0;
            vacc_reg <= '0;
            vdig_reg <= 1'b0;
            lbad_reg <= 1'b0;
            llat_reg <= '0;
            bcnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready || !ovalid_reg)
                ovalid_reg <= in_ch.valid;
            if (take)
            begin
                if (st != hrbp_pkg::ST_MORE)
                begin
                    pos_reg <= hrbp_pkg::P_METHOD0;
                    major_reg <= '0;
                    minor_reg <= '0;
                    seen_reg <= 1'b0;
                    nmpos_reg <= '0;
                    nmis_reg <= 1'b0;
                    inlen_reg <= 1'b0;
                    vacc_reg <= '0;
                    vdig_reg <= 1'b0;
                    lbad_reg <= 1'b0;
                    llat_reg <= '0;
                    bcnt_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_next;
                    major_reg <= major_next;
                    minor_reg <= minor_next;
                    seen_reg <= seen_next;
                    nmpos_reg <= nmpos_next;
                    nmis_reg <= nmis_next;
                    inlen_reg <= inlen_next;
                    vacc_reg <= vacc_next;
                    vdig_reg <= vdig_next;
                    lbad_reg <= lbad_next;
                    llat_reg <= llat_next;
                    bcnt_reg <= bcnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            st_reg <= st;
            tag_reg <= tag;
            byte_reg <= c;
            hs_reg <= hs;
            vmaj_reg <= 16'(major_next);
            vmin_reg <= 16'(minor_next);
            blen_reg <= show_len ? 32'(llat_out) : 32'd0;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.parse_status = st_reg;
    assign out_ch.field_tag = tag_reg;
    assign out_ch.out_byte = byte_reg;
    assign out_ch.header_start = hs_reg;
    assign out_ch.version_major = vmaj_reg;
    assign out_ch.version_minor = vmin_reg;
    assign out_ch.body_length = blen_reg;

endmodule

### bench/hrbp_result_checker.sv
module hrbp_result_checker
(
    input  logic      clk,
    input  logic      rst_n,
    hrbp_in_if.sink   in_mon,
    hrbp_out_if.sink  out_mon,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [111:0] CL_TEXT = "content-length";

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  tag;
        logic [7:0]  data;
        logic        hstart;
        logic [15:0] vmaj;
        logic [15:0] vmin;
        logic [31:0] blen;
    } parse_result_t;

    parse_result_t expected_results[$];

    logic [4:0]  pos;
    logic [15:0] maj_acc, min_acc;
    logic        hdr_seen, mismatch, cl_hdr, has_digit, len_bad;
    logic [3:0]  match_pos;
    logic [31:0] val_acc, len_latched, body_cnt;

    function automatic logic tok(input logic [7:0] c);
        logic s;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", " ", 8'd9: s = 1'b1;
            default: s = 1'b0;
        endcase
        return (c < 8'd127) && (c > 8'd31) && !s;
    endfunction

    function automatic logic [15:0] ver_next(input logic [15:0] a, input logic [7:0] c);
        logic [31:0] v;
        v = a * 32'd10 + (c - "0");
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic clear_parser();
        pos = hrbp_pkg::P_METHOD0; maj_acc = '0; min_acc = '0; hdr_seen = 0;
        match_pos = '0; mismatch = 0; cl_hdr = 0; val_acc = '0;
        has_digit = 0; len_bad = 0; len_latched = '0; body_cnt = '0;
    endtask

    task automatic close_header();
        if (cl_hdr)
        begin
            if (!has_digit) len_bad = 1;
            else len_latched = val_acc;
        end
        cl_hdr = 0; val_acc = '0; has_digit = 0;
    endtask

    task automatic take_name(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (!mismatch && match_pos < hrbp_pkg::CL_NAME_LEN
            && lc == CL_TEXT[8*(13-match_pos) +: 8])
            match_pos++;
        else
            mismatch = 1;
    endtask

    task automatic take_value(input logic [7:0] c);
        logic [35:0] v;
        if (!cl_hdr) return;
        if (!(c >= "0" && c <= "9"))
        begin
            len_bad = 1;
            return;
        end
        v = val_acc * 36'd10 + (c - "0");
        if (v > 36'hFFFFFFFF) len_bad = 1;
        else
        begin
            val_acc = v[31:0];
            has_digit = 1;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        parse_result_t r;
        logic show;
        r = '0; r.status = hrbp_pkg::ST_MORE; r.tag = hrbp_pkg::TG_DELIM; r.data = c; show = 0;
        case (pos)
            hrbp_pkg::P_METHOD0, hrbp_pkg::P_METHOD:
                if (tok(c))
                begin
                    r.tag = hrbp_pkg::TG_METHOD; pos = hrbp_pkg::P_METHOD;
                end
                else if (c == " " && pos == hrbp_pkg::P_METHOD) pos = hrbp_pkg::P_URI;
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_URI:
                if (c == " ") pos = hrbp_pkg::P_H;
                else if (!(c <= 8'd31 || c == 8'd127)) r.tag = hrbp_pkg::TG_URI;
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_H:
                if (c == "H") pos = hrbp_pkg::P_T1; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_T1:
                if (c == "T") pos = hrbp_pkg::P_T2; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_T2:
                if (c == "T") pos = hrbp_pkg::P_P; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_P:
                if (c == "P") pos = hrbp_pkg::P_SLASH; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_SLASH:
                if (c == "/") pos = hrbp_pkg::P_MAJ0; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_MAJ0, hrbp_pkg::P_MAJ:
                if (c >= "0" && c <= "9")
                begin
                    r.tag = hrbp_pkg::TG_VER; maj_acc = ver_next(maj_acc, c);
                    pos = hrbp_pkg::P_MAJ;
                end
                else if (c == "." && pos == hrbp_pkg::P_MAJ) pos = hrbp_pkg::P_MIN0;
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_MIN0, hrbp_pkg::P_MIN:
                if (c >= "0" && c <= "9")
                begin
                    r.tag = hrbp_pkg::TG_VER; min_acc = ver_next(min_acc, c);
                    pos = hrbp_pkg::P_MIN;
                end
                else if (c == 8'd13 && pos == hrbp_pkg::P_MIN) pos = hrbp_pkg::P_REQLF;
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_REQLF, hrbp_pkg::P_LINELF:
                if (c == 8'd10) pos = hrbp_pkg::P_LINE; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_LINE:
                if (c == " " || c == 8'd9)
                begin
                    if (hdr_seen) pos = hrbp_pkg::P_CONTWS; else r.status = hrbp_pkg::ST_ERR;
                end
                else if (tok(c))
                begin
                    close_header();
                    hdr_seen = 1; match_pos = '0; mismatch = 0;
                    take_name(c);
                    r.tag = hrbp_pkg::TG_NAME; r.hstart = 1; pos = hrbp_pkg::P_NAME;
                end
                else if (c == 8'd13)
                begin
                    close_header();
                    pos = hrbp_pkg::P_FINLF;
                end
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_NAME:
                if (tok(c))
                begin
                    take_name(c); r.tag = hrbp_pkg::TG_NAME;
                end
                else if (c == ":")
                begin
                    cl_hdr = !mismatch && match_pos == hrbp_pkg::CL_NAME_LEN;
                    pos = hrbp_pkg::P_COLSP;
                end
                else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_COLSP:
                if (c == " ") pos = hrbp_pkg::P_VALUE; else r.status = hrbp_pkg::ST_ERR;
            hrbp_pkg::P_CONTWS, hrbp_pkg::P_VALUE:
                if (!(pos == hrbp_pkg::P_CONTWS && (c == " " || c == 8'd9)))
                begin
                    if (c == 8'd13) pos = hrbp_pkg::P_LINELF;
                    else if (c > 8'd31 && c < 8'd127)
                    begin
                        take_value(c); r.tag = hrbp_pkg::TG_VALUE; pos = hrbp_pkg::P_VALUE;
                    end
                    else r.status = hrbp_pkg::ST_ERR;
                end
            hrbp_pkg::P_FINLF:
                if (c != 8'd10 || len_bad) r.status = hrbp_pkg::ST_ERR;
                else
                begin
                    show = 1; body_cnt = '0;
                    if (len_latched == 0) r.status = hrbp_pkg::ST_DONE;
                    else pos = hrbp_pkg::P_BODY;
                end
            hrbp_pkg::P_BODY:
                begin
                    r.tag = hrbp_pkg::TG_BODY; show = 1; body_cnt++;
                    if (body_cnt >= len_latched) r.status = hrbp_pkg::ST_DONE;
                end
            default: r.status = hrbp_pkg::ST_ERR;
        endcase
        if (r.status == hrbp_pkg::ST_ERR) r.tag = hrbp_pkg::TG_DELIM;
        r.vmaj = maj_acc; r.vmin = min_acc;
        r.blen = show ? len_latched : '0;
        expected_results.insert(expected_results.size(), r);
        if (r.status != hrbp_pkg::ST_MORE) clear_parser();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        clear_parser();
    end

    always @(posedge clk)
    begin
        parse_result_t e;
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", out_mon.out_byte, 0);
                else
                begin
                    e = expected_results.pop_front();
                    if (out_mon.parse_status !== e.status)
                        report_mismatch("parse_status", out_mon.parse_status, e.status);
                    if (out_mon.field_tag !== e.tag)
                        report_mismatch("field_tag", out_mon.field_tag, e.tag);
                    if (out_mon.out_byte !== e.data)
                        report_mismatch("out_byte", out_mon.out_byte, e.data);
                    if (out_mon.header_start !== e.hstart)
                        report_mismatch("header_start", out_mon.header_start, e.hstart);
                    if (out_mon.version_major !== e.vmaj)
                        report_mismatch("version_major", out_mon.version_major, e.vmaj);
                    if (out_mon.version_minor !== e.vmin)
                        report_mismatch("version_minor", out_mon.version_minor, e.vmin);
                    if (out_mon.body_length !== e.blen)
                        report_mismatch("body_length", out_mon.body_length, e.blen);
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_byte(in_mon.in_byte);
        end
        pending_count = expected_results.size();
    end
endmodule

### bench/tb_http_request_byte_parser_unit.sv
module tb_http_request_byte_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_LENGTH = 60;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count, pending_count;
    int   sent_count = 0;
    int   quiet_cycles = 0;
    logic calm_phase = 0;
    logic hold_req = 0;
    logic hold_taken = 0;
    int   hold_cycles = 0;
    logic [7:0] byte_queue[$];

    hrbp_in_if  in_ch();
    hrbp_out_if out_ch();

    http_request_byte_parser_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    hrbp_result_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                                   .fail_count(fail_count), .pending_count(pending_count));

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    task automatic put_byte(input logic [7:0] b);
        byte_queue.insert(byte_queue.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic string rand_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z")
                r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string rand_token(input int n);
        string r;
        string alpha;
        alpha = "abcXYZ019!#$%&'*+-.^_`|~";
        r = "";
        for (int i = 0; i < n; i++)
            r = {r, string'(alpha[$urandom_range(0, alpha.len() - 1)])};
        return r;
    endfunction

    task automatic add_request();
        int n_hdr, blen;
        string m;
        blen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        add_text({rand_token($urandom_range(1, 6)), " /", rand_token($urandom_range(0, 5))});
        if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(128, 255)));
        add_text(" HTTP/");
        add_text($sformatf("%0d.%0d\r\n", $urandom_range(0, 20), $urandom_range(0, 20)));
        n_hdr = $urandom_range(0, 3);
        for (int h = 0; h < n_hdr; h++)
        begin
            add_text({rand_token($urandom_range(1, 8)), ": ", rand_token($urandom_range(0, 6))});
            if ($urandom_range(0, 2) == 0) add_text({"\r\n\t", rand_token(2)});
            add_text("\r\n");
        end
        if (blen > 0 || $urandom_range(0, 1))
        begin
            m = $urandom_range(0, 9) == 0 ? $sformatf("%0dx", blen) : $sformatf("%0d", blen);
            add_text({rand_case("content-length"), ": ", m, "\r\n"});
        end
        add_text("\r\n");
        for (int i = 0; i < blen; i++)
            put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            for (int i = 0; i < 4; i++)
                put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_all();
        while (byte_queue.size() > 0)
        begin
            if (!calm_phase && $urandom_range(0, 99) < 14)
            begin
                in_ch.valid <= 0;
                @(posedge clk);
            end
            else
            begin
                in_ch.valid <= 1;
                in_ch.in_byte <= byte_queue.pop_front();
                @(posedge clk);
                while (!in_ch.ready) @(posedge clk);
                sent_count++;
            end
        end
        in_ch.valid <= 0;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_cycles <= HOLD_LENGTH;
            hold_taken <= 1;
            out_ch.ready <= 0;
        end
        else
            out_ch.ready <= calm_phase ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[http_request_byte_parser_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid <= 0;
        in_ch.in_byte <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        add_text("GET / HTTP/1.1\r\nHost: x\r\n\r\n");
        add_text("POST /a HTTP/99999.70000\r\nCONTENT-length: 3\r\n\r\n");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h7F);
        add_text(" X");
        add_text("A  HTTP/1.0\r\n x");
        add_text("A \x80 HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\n");
        add_text("A / HTTP/1.1\r\nContent-Length:  \r\n\r\n");
        add_text("A / HTTP/1.1\r\nContent-Length: 1\r\n 2\r\nContent-Length: 0\r\n\r\n");
        send_all();
        while (pending_count > 0) @(posedge clk);
        while (sent_count < 1450)
        begin
            if (sent_count > 400 && sent_count < 700) calm_phase = 1;
            else calm_phase = 0;
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 8; i++) put_byte(8'($urandom_range(0, 255)));
            else
                add_request();
            if (sent_count > 800) hold_req = 1;
            send_all();
            if (sent_count > 1000 && sent_count < 1100)
                while (pending_count > 0) @(posedge clk);
        end
        calm_phase = 0;
        while (pending_count > 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("[http_request_byte_parser_unit] OK");
        else
            $display("[http_request_byte_parser_unit] ERROR");
        $finish;
    end
endmodule

### files.f
sv/hrbp_pkg.sv
sv/hrbp_in_if.sv
sv/hrbp_out_if.sv
sv/http_request_byte_parser_unit.sv
bench/hrbp_result_checker.sv
bench/tb_http_request_byte_parser_unit.sv
